// ===== rtl/core/tcws_pkg.sv =====
// Package for the task check-in watchdog supervisor.
// Holds the event and result beat types, command codes and register indexes.
// No dependencies.
package tcws_pkg;

    localparam int MASK_WIDTH = 32;
    localparam int TIME_WIDTH = 32;
    localparam int CFG_WIDTH = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    typedef logic [MASK_WIDTH-1:0] mask_t;
    typedef logic [TIME_WIDTH-1:0] tick_t;

    typedef enum logic [2:0] {
        CMD_BEGIN     = 3'd0,
        CMD_PROGRESS  = 3'd1,
        CMD_FAULT     = 3'd2,
        CMD_STOP_WAKE = 3'd3,
        CMD_STEP      = 3'd4,
        CMD_FEED      = 3'd5
    } cmd_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_REQUIRED_MASK = 2'd0,
        REG_IDLE_OPTIONAL = 2'd1,
        REG_FEED_INTERVAL = 2'd2
    } cfg_index_t;

    localparam mask_t IDLE_OPTIONAL_RESET = mask_t'((1 << 7) | (1 << 8));
    localparam tick_t FEED_INTERVAL_RESET = tick_t'(1000);

    typedef struct packed {
        cmd_t  cmd;
        mask_t bits;
        tick_t now_ms;
        logic  screen_idle;
    } evt_t;

    typedef struct packed {
        logic  feed;
        logic  step_healthy;
        logic  stop_ready;
        mask_t missing_bits;
        mask_t fault_mask;
        logic  snap_valid;
        tick_t snap_time;
        mask_t snap_missing;
        mask_t snap_faults;
    } res_t;

endpackage

// ===== rtl/core/tcws_in_stage.sv =====
// Input register of the supervisor: holds one event beat until it moves on.
// Depends on tcws_pkg for the event beat type.
module tcws_in_stage (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          evt_valid,
    output logic          evt_stall,
    input  tcws_pkg::evt_t evt,
    input  logic          advance,
    output logic          hold_valid,
    output tcws_pkg::evt_t hold
);
    import tcws_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    evt_t hold_reg;
    logic take;

    assign evt_stall = hold_valid_reg && !advance;
    assign take = evt_valid && !evt_stall;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (advance)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_reg <= evt;
        end
    end

    assign hold_valid = hold_valid_reg;
    assign hold = hold_reg;

endmodule

// ===== rtl/core/tcws_eval.sv =====
// Supervisor state, configuration registers and the per-event update logic.
// Depends on tcws_pkg for types, command codes and register indexes.
module tcws_eval (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tcws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tcws_pkg::CFG_WIDTH-1:0]       cfg_data,
    input  logic                        commit,
    input  tcws_pkg::evt_t              item,
    output tcws_pkg::res_t              result
);
    import tcws_pkg::*;

    mask_t required_reg;
    mask_t idle_optional_reg;
    tick_t feed_interval_reg;

    mask_t progress_reg, progress_next;
    mask_t faults_reg, faults_next;
    mask_t last_missing_reg, last_missing_next;
    mask_t last_faults_reg, last_faults_next;
    tick_t last_feed_reg, last_feed_next;
    logic  stop_ok_reg, stop_ok_next;
    logic  skip_once_reg, skip_once_next;
    logic  snap_valid_reg, snap_valid_next;
    tick_t snap_time_reg, snap_time_next;
    mask_t snap_missing_reg, snap_missing_next;
    mask_t snap_faults_reg, snap_faults_next;

    mask_t req_eff;
    mask_t missing;
    tick_t elapsed;
    logic  healthy;
    logic  feed;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            required_reg <= '0;
            idle_optional_reg <= IDLE_OPTIONAL_RESET;
            feed_interval_reg <= FEED_INTERVAL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REQUIRED_MASK: required_reg <= mask_t'(cfg_data);
                REG_IDLE_OPTIONAL: idle_optional_reg <= mask_t'(cfg_data);
                REG_FEED_INTERVAL: feed_interval_reg <= tick_t'(cfg_data);
                default: ;
            endcase
        end
    end

    assign req_eff = item.screen_idle ? (required_reg & ~idle_optional_reg) : required_reg;
    assign missing = req_eff & ~progress_reg;
    assign elapsed = item.now_ms - last_feed_reg;

    always_comb
    begin
        progress_next = progress_reg;
        faults_next = faults_reg;
        last_missing_next = last_missing_reg;
        last_faults_next = last_faults_reg;
        last_feed_next = last_feed_reg;
        stop_ok_next = stop_ok_reg;
        skip_once_next = skip_once_reg;
        snap_valid_next = snap_valid_reg;
        snap_time_next = snap_time_reg;
        snap_missing_next = snap_missing_reg;
        snap_faults_next = snap_faults_reg;
        healthy = 1'b0;
        feed = 1'b0;
        case (item.cmd)
            CMD_BEGIN:
            begin
                progress_next = '0;
                faults_next = '0;
            end
            CMD_PROGRESS:
            begin
                progress_next = progress_reg | item.bits;
            end
            CMD_FAULT:
            begin
                faults_next = faults_reg | item.bits;
            end
            CMD_STOP_WAKE:
            begin
                stop_ok_next = 1'b0;
                skip_once_next = 1'b1;
            end
            CMD_STEP:
            begin
                if (skip_once_reg)
                begin
                    skip_once_next = 1'b0;
                    stop_ok_next = 1'b0;
                    last_missing_next = '0;
                    last_faults_next = '0;
                end
                else
                begin
                    last_missing_next = missing;
                    last_faults_next = faults_reg;
                    healthy = (missing == '0) && (faults_reg == '0);
                    stop_ok_next = healthy;
                    if (!healthy)
                    begin
                        snap_valid_next = 1'b1;
                        snap_time_next = item.now_ms;
                        snap_missing_next = missing;
                        snap_faults_next = faults_reg;
                    end
                    else if (elapsed >= feed_interval_reg)
                    begin
                        last_feed_next = item.now_ms;
                        feed = 1'b1;
                    end
                end
            end
            CMD_FEED:
            begin
                last_feed_next = item.now_ms;
                feed = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            progress_reg <= '0;
            faults_reg <= '0;
            last_missing_reg <= '0;
            last_faults_reg <= '0;
            last_feed_reg <= '0;
            stop_ok_reg <= 1'b1;
            skip_once_reg <= 1'b0;
            snap_valid_reg <= 1'b0;
            snap_time_reg <= '0;
            snap_missing_reg <= '0;
            snap_faults_reg <= '0;
        end
        else if (commit)
        begin
            progress_reg <= progress_next;
            faults_reg <= faults_next;
            last_missing_reg <= last_missing_next;
            last_faults_reg <= last_faults_next;
            last_feed_reg <= last_feed_next;
            stop_ok_reg <= stop_ok_next;
            skip_once_reg <= skip_once_next;
            snap_valid_reg <= snap_valid_next;
            snap_time_reg <= snap_time_next;
            snap_missing_reg <= snap_missing_next;
            snap_faults_reg <= snap_faults_next;
        end
    end

    always_comb
    begin
        result.feed = feed;
        result.step_healthy = healthy;
        result.stop_ready = stop_ok_next;
        result.missing_bits = last_missing_next;
        result.fault_mask = last_faults_next;
        result.snap_valid = snap_valid_next;
        result.snap_time = snap_time_next;
        result.snap_missing = snap_missing_next;
        result.snap_faults = snap_faults_next;
    end

    a_stop_wake_arms_skip: assert property (@(posedge clk) disable iff (!rst_n)
        commit && item.cmd == CMD_STOP_WAKE |=> skip_once_reg && !stop_ok_reg)
        else $error("stop wake did not arm the skipped step");

    a_skipped_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
        commit && item.cmd == CMD_STEP && skip_once_reg
        |=> !skip_once_reg && !stop_ok_reg && last_missing_reg == '0 && last_faults_reg == '0)
        else $error("skipped step left stale check results");

    a_healthy_step_allows_stop: assert property (@(posedge clk) disable iff (!rst_n)
        commit && healthy |=> stop_ok_reg && last_missing_reg == '0 && last_faults_reg == '0)
        else $error("healthy step did not grant stop permission");

    a_snapshot_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(snap_valid_reg))
        else $error("snapshot valid flag dropped");

    a_feed_only_when_healthy_step: assert property (@(posedge clk) disable iff (!rst_n)
        commit && feed && item.cmd == CMD_STEP |=> last_feed_reg == $past(item.now_ms)
        && stop_ok_reg)
        else $error("step feed without a healthy window");

endmodule

// ===== rtl/core/tcws_out_stage.sv =====
// Result register of the supervisor: holds one result beat until it is taken.
// Depends on tcws_pkg for the result beat type.
module tcws_out_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           hold_valid,
    input  tcws_pkg::res_t result,
    output logic           advance,
    output logic           res_valid,
    input  logic           res_stall,
    output tcws_pkg::res_t res
);
    import tcws_pkg::*;

    logic res_valid_reg;
    logic res_valid_next;
    res_t res_reg;

    assign advance = hold_valid && (!res_valid_reg || !res_stall);

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (advance)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= result;
        end
    end

    assign res_valid = res_valid_reg;
    assign res = res_reg;

endmodule

// ===== rtl/core/task_checkin_watchdog_supervisor_top.sv =====
// Task check-in watchdog supervisor: one event beat in, one result beat out, one per cycle
// unless the result side stalls. Each event is registered, evaluated against the supervisor
// state combinationally, and its result is then registered in the output register; a new
// event may be accepted every cycle, limited only by stall on the result side. The state
// update of an event commits as it passes from the input register to the result register,
// so results follow event order exactly. Configuration writes take effect at the next
// clock edge and are meant for times when no event is in flight. After reset the required
// mask is 0, the idle-optional mask is 0x180 and the feed interval is 1000 ms.
// Depends on tcws_pkg, tcws_in_stage, tcws_eval and tcws_out_stage.
module task_checkin_watchdog_supervisor_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 evt_valid,
    output logic                                 evt_stall,
    input  tcws_pkg::evt_t                       evt,
    output logic                                 res_valid,
    input  logic                                 res_stall,
    output tcws_pkg::res_t                       res,
    input  logic                                 cfg_we,
    input  logic [tcws_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [tcws_pkg::CFG_WIDTH-1:0]       cfg_data
);
    import tcws_pkg::*;

    logic advance;
    logic hold_valid;
    evt_t hold;
    res_t result;

    tcws_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .evt_valid  (evt_valid),
        .evt_stall  (evt_stall),
        .evt        (evt),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold       (hold)
    );

    tcws_eval u_eval (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .commit    (advance),
        .item      (hold),
        .result    (result)
    );

    tcws_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .hold_valid (hold_valid),
        .result     (result),
        .advance    (advance),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res        (res)
    );

endmodule

// ===== sim/task_checkin_watchdog_supervisor_top_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the task check-in watchdog supervisor top level.
// Drives event beats, predicts every result beat from its own model of the supervisor
// and compares each field. Depends on tcws_pkg and task_checkin_watchdog_supervisor_top.
module task_checkin_watchdog_supervisor_top_test;

    import tcws_pkg::*;

    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;

    logic                       clk;
    logic                       rst_n;
    logic                       evt_valid;
    logic                       evt_stall;
    evt_t                       evt;
    logic                       res_valid;
    logic                       res_stall;
    res_t                       res;
    logic                       cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [CFG_WIDTH-1:0]       cfg_data;

    mask_t watch_required;
    mask_t watch_idle_opt;
    tick_t watch_interval;
    mask_t win_progress;
    mask_t win_faults;
    mask_t chk_missing;
    mask_t chk_faults;
    tick_t last_feed_tick;
    logic  stop_permit;
    logic  skip_next_step;
    logic  snap_held;
    tick_t snap_tick;
    mask_t snap_missing_q;
    mask_t snap_faults_q;

    res_t  pending_results[$];
    int    error_count;
    int    events_sent;
    int    sender_idle_pct;
    int    receiver_stall_pct;
    tick_t now_tick;

    task_checkin_watchdog_supervisor_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt_valid (evt_valid),
        .evt_stall (evt_stall),
        .evt       (evt),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(negedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
    end

    function automatic res_t supervise_event(input evt_t e);
        res_t  r;
        mask_t need;
        tick_t elapsed;
        logic  fed;
        logic  healthy;
        fed = 1'b0;
        healthy = 1'b0;
        case (e.cmd)
            CMD_BEGIN:
            begin
                win_progress = '0;
                win_faults = '0;
            end
            CMD_PROGRESS: win_progress = win_progress | e.bits;
            CMD_FAULT: win_faults = win_faults | e.bits;
            CMD_STOP_WAKE:
            begin
                stop_permit = 1'b0;
                skip_next_step = 1'b1;
            end
            CMD_STEP:
            begin
                if (skip_next_step)
                begin
                    skip_next_step = 1'b0;
                    stop_permit = 1'b0;
                    chk_missing = '0;
                    chk_faults = '0;
                end
                else
                begin
                    need = watch_required;
                    if (e.screen_idle)
                        need = need & ~watch_idle_opt;
                    chk_missing = need & ~win_progress;
                    chk_faults = win_faults;
                    healthy = (chk_missing == '0) && (chk_faults == '0);
                    stop_permit = healthy;
                    elapsed = e.now_ms - last_feed_tick;
                    if (!healthy)
                    begin
                        snap_held = 1'b1;
                        snap_tick = e.now_ms;
                        snap_missing_q = chk_missing;
                        snap_faults_q = chk_faults;
                    end
                    else if (elapsed >= watch_interval)
                    begin
                        last_feed_tick = e.now_ms;
                        fed = 1'b1;
                    end
                end
            end
            CMD_FEED:
            begin
                last_feed_tick = e.now_ms;
                fed = 1'b1;
            end
            default: ;
        endcase
        r.feed = fed;
        r.step_healthy = healthy;
        r.stop_ready = stop_permit;
        r.missing_bits = chk_missing;
        r.fault_mask = chk_faults;
        r.snap_valid = snap_held;
        r.snap_time = snap_tick;
        r.snap_missing = snap_missing_q;
        r.snap_faults = snap_faults_q;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string what, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch(what, got, want);
    endtask

    always @(posedge clk)
    begin : result_check
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with nothing pending", 64'd1, 64'd0);
            else
            begin
                want = pending_results.pop_front();
                check_field("feed", 64'(res.feed), 64'(want.feed));
                check_field("step_healthy", 64'(res.step_healthy), 64'(want.step_healthy));
                check_field("stop_ready", 64'(res.stop_ready), 64'(want.stop_ready));
                check_field("missing_bits", 64'(res.missing_bits), 64'(want.missing_bits));
                check_field("fault_mask", 64'(res.fault_mask), 64'(want.fault_mask));
                check_field("snap_valid", 64'(res.snap_valid), 64'(want.snap_valid));
                check_field("snap_time", 64'(res.snap_time), 64'(want.snap_time));
                check_field("snap_missing", 64'(res.snap_missing), 64'(want.snap_missing));
                check_field("snap_faults", 64'(res.snap_faults), 64'(want.snap_faults));
            end
        end
    end

    function automatic evt_t make_event(input cmd_t c, input mask_t b, input tick_t t,
                                        input logic idle);
        evt_t e;
        e.cmd = c;
        e.bits = b;
        e.now_ms = t;
        e.screen_idle = idle;
        return e;
    endfunction

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_event(input evt_t e);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            evt_valid = 1'b0;
            @(negedge clk);
        end
        evt_valid = 1'b1;
        evt = e;
        do
            @(posedge clk);
        while (evt_stall);
        pending_results.push_back(supervise_event(e));
        events_sent++;
        @(negedge clk);
    endtask

    task automatic wait_for_results;
        evt_valid = 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_WIDTH-1:0] value);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            REG_REQUIRED_MASK: watch_required = value;
            REG_IDLE_OPTIONAL: watch_idle_opt = value;
            REG_FEED_INTERVAL: watch_interval = value;
            default: ;
        endcase
    endtask

    task automatic advance_clock;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            now_tick = now_tick + $urandom_range(0, 1200);
        else if (pick < 90)
            now_tick = now_tick + $urandom_range(0, 3);
        else
            now_tick = now_tick + $urandom;
    endtask

    task automatic test_reset_state;
        send_event(make_event(cmd_t'(CMD_SPARE_A), 32'hFFFF_FFFF, 32'd5, 1'b1));
        send_event(make_event(cmd_t'(CMD_SPARE_B), 32'h0000_0000, 32'd6, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd0, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd999, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd1000, 1'b0));
        send_event(make_event(CMD_FEED, '0, 32'hFFFF_FFFF, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd998, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd999, 1'b0));
    endtask

    task automatic test_health_check;
        wait_for_results();
        write_reg(REG_REQUIRED_MASK, 32'hFFFF_FFFF);
        send_event(make_event(CMD_BEGIN, '0, 32'd2000, 1'b0));
        send_event(make_event(CMD_PROGRESS, 32'hFFFF_FE7F, 32'd2000, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd3000, 1'b1));
        send_event(make_event(CMD_STEP, '0, 32'd3001, 1'b0));
        send_event(make_event(CMD_FAULT, 32'h8000_0001, 32'd3002, 1'b0));
        send_event(make_event(CMD_PROGRESS, 32'h0000_0180, 32'd3003, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd3004, 1'b0));
        send_event(make_event(CMD_BEGIN, '0, 32'd3005, 1'b0));
        send_event(make_event(CMD_PROGRESS, 32'hFFFF_FFFF, 32'd3006, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd4500, 1'b0));
    endtask

    task automatic test_stop_wake;
        send_event(make_event(CMD_STOP_WAKE, '0, 32'd4600, 1'b0));
        send_event(make_event(CMD_STOP_WAKE, '0, 32'd4601, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd4602, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd4603, 1'b0));
    endtask

    task automatic test_zero_interval;
        wait_for_results();
        write_reg(REG_FEED_INTERVAL, 32'd0);
        send_event(make_event(CMD_STEP, '0, 32'd5000, 1'b0));
        send_event(make_event(CMD_STEP, '0, 32'd5000, 1'b1));
    endtask

    task automatic send_noise;
        int count;
        tick_t t;
        count = $urandom_range(1, 3);
        repeat (count)
        begin
            t = ($urandom_range(0, 1) != 0) ? tick_t'($urandom) : now_tick;
            send_event(make_event(cmd_t'($urandom_range(0, 7)), $urandom, t,
                                  1'($urandom_range(0, 1))));
        end
    endtask

    task automatic run_window;
        int    marks;
        logic  idle;
        logic  good;
        mask_t noise;
        idle = 1'($urandom_range(0, 1));
        good = ($urandom_range(0, 99) < 70);
        marks = $urandom_range(0, 3);
        send_event(make_event(CMD_BEGIN, $urandom, now_tick, idle));
        repeat (marks)
        begin
            noise = $urandom & $urandom & $urandom;
            send_event(make_event(CMD_PROGRESS, (watch_required & $urandom) | noise,
                                  now_tick, idle));
        end
        if (good)
        begin
            noise = ($urandom_range(0, 1) != 0) ? '0 : mask_t'($urandom);
            send_event(make_event(CMD_PROGRESS, watch_required | noise, now_tick, idle));
        end
        if ($urandom_range(0, 99) < 15)
            send_event(make_event(CMD_FAULT, $urandom & $urandom, now_tick, idle));
        if ($urandom_range(0, 99) < 10)
        begin
            repeat ($urandom_range(1, 2))
                send_event(make_event(CMD_STOP_WAKE, $urandom, now_tick, idle));
        end
        if ($urandom_range(0, 99) < 8)
            send_event(make_event(CMD_FEED, $urandom, now_tick, idle));
        advance_clock();
        send_event(make_event(CMD_STEP, $urandom, now_tick, idle));
        if ($urandom_range(0, 99) < 20)
        begin
            advance_clock();
            send_event(make_event(CMD_STEP, $urandom, now_tick, 1'($urandom_range(0, 1))));
        end
    endtask

    task automatic run_random_phase(input int beats, input mask_t required,
                                    input mask_t idle_opt, input tick_t interval,
                                    input int sender_pct, input int receiver_pct);
        int target;
        wait_for_results();
        write_reg(REG_REQUIRED_MASK, required);
        write_reg(REG_IDLE_OPTIONAL, idle_opt);
        write_reg(REG_FEED_INTERVAL, interval);
        sender_idle_pct = sender_pct;
        receiver_stall_pct = receiver_pct;
        target = events_sent + beats;
        while (events_sent < target)
        begin
            if ($urandom_range(0, 99) < 20)
                send_noise();
            else
                run_window();
        end
    endtask

    task automatic test_random_traffic;
        now_tick = 32'd6000;
        run_random_phase(350, $urandom, $urandom, 32'd1000, 0, 0);
        run_random_phase(350, 32'h0000_0000, 32'hFFFF_FFFF, 32'd1, 57, 0);
        run_random_phase(350, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 0, 57);
        run_random_phase(350, $urandom & $urandom, $urandom, $urandom_range(1, 2000), 25, 25);
        run_random_phase(350, $urandom, 32'h0000_0180, 32'd500, 0, 0);
    endtask

    initial
    begin
        rst_n = 1'b0;
        evt_valid = 1'b0;
        evt = '0;
        res_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_REQUIRED_MASK;
        cfg_data = '0;
        error_count = 0;
        events_sent = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        now_tick = '0;
        watch_required = '0;
        watch_idle_opt = IDLE_OPTIONAL_RESET;
        watch_interval = FEED_INTERVAL_RESET;
        win_progress = '0;
        win_faults = '0;
        chk_missing = '0;
        chk_faults = '0;
        last_feed_tick = '0;
        stop_permit = 1'b1;
        skip_next_step = 1'b0;
        snap_held = 1'b0;
        snap_tick = '0;
        snap_missing_q = '0;
        snap_faults_q = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_state();
        test_health_check();
        test_stop_wake();
        test_zero_interval();
        test_random_traffic();

        wait_for_results();
        repeat (10) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("%0t: timeout with %0d results pending", $time, pending_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
